### sv/erv_pkg.sv
// Shared constants, codes and handshake structs of the varint/Elias/Rice bit encoder.
`timescale 1ns / 1ps
`default_nettype none

package erv_pkg;

  // Default encoding width of a value
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths of the request and result channels
  localparam int IN_VALUE_W = 32;
  localparam int FUNC_W     = 3;
  localparam int WIDTH_W    = 6;
  localparam int BYTE_W     = 8;
  localparam int RICE_K_W   = 5;

  // Varint framing: 7-bit groups, stop marker in bit 7
  localparam int VARINT_GROUP = 7;
  localparam int VARINT_STOP  = 128;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_RICE_K = '0;

  // Operation codes of a request
  typedef enum logic [FUNC_W-1:0] {
    FN_RAW_WORD = 3'd0,
    FN_RAW_BYTE = 3'd1,
    FN_GAMMA    = 3'd2,
    FN_DELTA    = 3'd3,
    FN_RICE     = 3'd4,
    FN_VARINT   = 3'd5,
    FN_FLUSH    = 3'd6
  } func_t;

  // Command from the sequencer to the bit packer
  typedef struct packed {
    logic              merge;   // append up to avail bits of bits
    logic              align;   // emit a partly filled byte
    logic [BYTE_W-1:0] bits;
    logic [3:0]        avail;   // 0..8 bits offered
  } pk_req_t;

  // Status from the bit packer back to the sequencer
  typedef struct packed {
    logic              fire;      // command completed this cycle
    logic [3:0]        take;      // bits consumed by a merge
    logic              emit;      // a byte leaves the packer
    logic [BYTE_W-1:0] emit_byte;
  } pk_rsp_t;

endpackage

`default_nettype wire

### sv/erv_in_if.sv
// Request channel of the bit encoder: operation, value and raw width.
`timescale 1ns / 1ps
`default_nettype none

interface erv_in_if;
  import erv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [IN_VALUE_W-1:0] value;
  logic [WIDTH_W-1:0]    width;

  modport source (output valid, output func, output value, output width, input ready);
  modport sink   (input valid, input func, input value, input width, output ready);
endinterface

`default_nettype wire

### sv/erv_out_if.sv
// Result channel of the bit encoder: one packed byte with last and error flags.
`timescale 1ns / 1ps
`default_nettype none

interface erv_out_if;
  import erv_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  logic              error;

  modport source (output valid, output out_byte, output last, output error, input ready);
  modport sink   (input valid, input out_byte, input last, input error, output ready);
endinterface

`default_nettype wire

### sv/erv_packer.sv
// Bit packer: merges up to eight bits a cycle into the partial byte, LSB first; stalls on push_ok.
`timescale 1ns / 1ps
`default_nettype none

module erv_packer (
  input  logic             clk,
  input  logic             rst_n,
  input  erv_pkg::pk_req_t req,
  input  logic             push_ok,
  output erv_pkg::pk_rsp_t rsp
);
  import erv_pkg::*;

  logic [BYTE_W-1:0]   part_r, part_nxt;
  logic [2:0]          fill_r, fill_nxt;
  logic [3:0]          room;
  logic [3:0]          take;
  logic [3:0]          sum;
  logic [BYTE_W-1:0]   mask8;
  logic [BYTE_W-1:0]   shifted;
  logic [BYTE_W-1:0]   merged;

  // Merge or align the partial byte
  always_comb begin
    room    = 4'(BYTE_W) - {1'b0, fill_r};
    take    = (req.avail < room) ? req.avail : room;
    mask8   = BYTE_W'((9'd1 << take) - 9'd1);
    shifted = (req.bits & mask8) << fill_r;
    merged  = part_r | shifted;
    sum     = {1'b0, fill_r} + take;

    part_nxt    = part_r;
    fill_nxt    = fill_r;
    rsp         = '0;
    rsp.take    = take;

    if (req.merge) begin
      if (sum == 4'(BYTE_W)) begin
        // byte completes: needs room downstream
        if (push_ok) begin
          rsp.fire      = 1'b1;
          rsp.emit      = 1'b1;
          rsp.emit_byte = merged;
          part_nxt      = '0;
          fill_nxt      = '0;
        end
      end else begin
        rsp.fire = 1'b1;
        part_nxt = merged;
        fill_nxt = sum[2:0];
      end
    end else if (req.align) begin
      if (fill_r == '0) begin
        rsp.fire = 1'b1;
      end else if (push_ok) begin
        rsp.fire      = 1'b1;
        rsp.emit      = 1'b1;
        rsp.emit_byte = part_r;
        part_nxt      = '0;
        fill_nxt      = '0;
      end
    end
  end

  // Hold the partial byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      fill_r <= '0;
    end else begin
      part_r <= part_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Unused high bits of the partial byte stay clear
  a_part_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (part_r == '0))
    else $error("partial byte holds bits with an empty fill count");

  a_take_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (req.merge && rsp.fire) |=> (fill_r == $past(sum[2:0])))
    else $error("fill count lost bits of a merge");

  a_emit_fire: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.emit |-> (push_ok && rsp.fire))
    else $error("byte emitted without room downstream");

endmodule

`default_nettype wire

### sv/elias_rice_varint_bit_encoder_unit.sv
// Top level of the Elias gamma/delta, Rice and varint bit-packing encoder.
//
// Usage: each request on in_if carries func, value and width. Code bits are
// appended LSB first to a byte stream; every completed byte leaves on out_if
// as one result, the final result of a request has last set. Raw byte,
// varint and flush first send out a partly filled byte. A zero value for
// gamma or delta, or a Rice quotient that wraps, gives one result with error
// set and changes nothing. rice_k is written over the APB port (address 0).
// Timing: one request at a time; in_if.ready is high only while idle. A
// request passes an align step for raw byte, varint and flush, a length
// search that steps over the coded value one byte (8 bits) at a time, up
// to four code segments, and packer merges of up to eight bits, split at
// byte boundaries; varint sends one byte per group. An error or ignored
// code goes straight from idle to the end of the request.
// The last byte of a request waits in a one-byte holding stage until the
// request ends, so results trail the packer by one byte.
// Reset clears the partial byte, rice_k and both output stages. When the
// receiver stalls, the packer stops at the next completed byte and resumes
// once out_if takes the waiting result; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module elias_rice_varint_bit_encoder_unit #(
  parameter int VALUE_BITS = erv_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  erv_in_if.sink                     in_if,
  erv_out_if.source                  out_if,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [erv_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [erv_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [erv_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import erv_pkg::*;

  localparam int DW      = VALUE_BITS;
  localparam int IW      = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
  localparam int K_MAX   = (1 << RICE_K_W) - 1;
  localparam int SEG_MAX = (VALUE_BITS > K_MAX) ? VALUE_BITS : K_MAX;
  localparam int CW      = $clog2(SEG_MAX + 1);
  localparam int LLW     = $clog2(CW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LEN, S_PACK, S_ALIGN, S_VARINT, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    NS_GAMMA_B, NS_DELTA_B, NS_DELTA_C, NS_RICE_T, NS_END
  } nseg_t;

  // Bit length of a byte
  function automatic logic [3:0] bitlen8(input logic [BYTE_W-1:0] x);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (x[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Bit length of a code length
  function automatic logic [LLW-1:0] bitlen_len(input logic [CW-1:0] x);
    logic [LLW-1:0] n;
    n = '0;
    for (int i = 0; i < CW; i++) begin
      if (x[i]) n = LLW'(i + 1);
    end
    return n;
  endfunction

  localparam logic [DW-1:0] DW_ONE = DW'(1);

  state_t            state_r, state_nxt;
  func_t             op_r, op_nxt;
  nseg_t             nseg_r, nseg_nxt;
  logic [DW-1:0]     v_r, v_nxt;
  logic [DW-1:0]     x_r, x_nxt;
  logic [DW-1:0]     lx_r, lx_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [DW-1:0]     seg_data_r, seg_data_nxt;
  logic [CW-1:0]     seg_cnt_r, seg_cnt_nxt;
  logic [RICE_K_W-1:0] rice_k_r, rice_k_nxt;

  logic              pend_valid_r, pend_valid_nxt;
  logic [BYTE_W-1:0] pend_byte_r, pend_byte_nxt;
  logic              pend_err_r, pend_err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;

  logic              out_free;
  logic              can_push;
  logic              prod_valid;
  logic [BYTE_W-1:0] prod_byte;
  logic              prod_err;
  logic [DW-1:0]     v_in;
  logic [DW-1:0]     q1_in;
  logic [CW-1:0]     w_sat;
  logic [CW-1:0]     l_fin;
  logic [LLW-1:0]    ll_fin;
  logic              cfg_wr;

  pk_req_t           pk_req;
  pk_rsp_t           pk_rsp;

  erv_packer u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (pk_req),
    .push_ok (can_push),
    .rsp     (pk_rsp)
  );

  // Request decode: masked value, Rice quotient plus one, clipped raw width
  always_comb begin
    v_in  = DW'(in_if.value[IW-1:0]);
    q1_in = (v_in >> rice_k_r) + DW_ONE;
    w_sat = (int'(in_if.width) > VALUE_BITS) ? CW'(VALUE_BITS) : CW'(in_if.width);
    l_fin  = len_r + CW'(bitlen8(lx_r[BYTE_W-1:0]));
    ll_fin = bitlen_len(l_fin);
  end

  assign out_free  = !out_valid_r || out_if.ready;
  assign can_push  = !pend_valid_r || out_free;
  assign in_if.ready = (state_r == S_IDLE);

  // Sequencer and output stages
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    nseg_nxt     = nseg_r;
    v_nxt        = v_r;
    x_nxt        = x_r;
    lx_nxt       = lx_r;
    len_nxt      = len_r;
    seg_data_nxt = seg_data_r;
    seg_cnt_nxt  = seg_cnt_r;

    pk_req       = '0;
    pk_req.bits  = seg_data_r[BYTE_W-1:0];
    pk_req.avail = (seg_cnt_r >= CW'(BYTE_W)) ? 4'(BYTE_W) : 4'(seg_cnt_r);

    prod_valid = 1'b0;
    prod_byte  = '0;
    prod_err   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt  = func_t'(in_if.func);
          v_nxt   = v_in;
          x_nxt   = v_in;
          lx_nxt  = v_in;
          len_nxt = '0;
          unique case (func_t'(in_if.func))
            FN_RAW_WORD: begin
              seg_data_nxt = v_in;
              seg_cnt_nxt  = w_sat;
              nseg_nxt     = NS_END;
              state_nxt    = S_PACK;
            end
            FN_RAW_BYTE, FN_VARINT, FN_FLUSH: begin
              state_nxt = S_ALIGN;
            end
            FN_GAMMA, FN_DELTA: begin
              if (v_in == '0) begin
                prod_valid = 1'b1;
                prod_err   = 1'b1;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_LEN;
              end
            end
            FN_RICE: begin
              if (q1_in == '0) begin
                prod_valid = 1'b1;
                prod_err   = 1'b1;
                state_nxt  = S_DONE;
              end else begin
                x_nxt     = q1_in;
                lx_nxt    = q1_in;
                state_nxt = S_LEN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Search the bit length a byte at a time, then load the unary part
      S_LEN: begin
        if ((lx_r >> BYTE_W) != '0) begin
          lx_nxt  = lx_r >> BYTE_W;
          len_nxt = len_r + CW'(BYTE_W);
        end else begin
          len_nxt   = l_fin;
          state_nxt = S_PACK;
          if (op_r == FN_GAMMA) begin
            seg_data_nxt = DW_ONE << (l_fin - CW'(1));
            seg_cnt_nxt  = l_fin;
            nseg_nxt     = NS_GAMMA_B;
          end else begin
            seg_data_nxt = DW_ONE << (ll_fin - LLW'(1));
            seg_cnt_nxt  = CW'(ll_fin);
            nseg_nxt     = NS_DELTA_B;
          end
        end
      end

      // Feed the current segment to the packer, load the next one when empty
      S_PACK: begin
        if (seg_cnt_r == '0) begin
          unique case (nseg_r)
            NS_GAMMA_B: begin
              seg_data_nxt = x_r;
              seg_cnt_nxt  = len_r - CW'(1);
              nseg_nxt     = NS_END;
            end
            NS_DELTA_B: begin
              seg_data_nxt = DW'(len_r);
              seg_cnt_nxt  = CW'(bitlen_len(len_r)) - CW'(1);
              nseg_nxt     = NS_DELTA_C;
            end
            NS_DELTA_C: begin
              seg_data_nxt = x_r;
              seg_cnt_nxt  = len_r - CW'(1);
              nseg_nxt     = (op_r == FN_RICE) ? NS_RICE_T : NS_END;
            end
            NS_RICE_T: begin
              seg_data_nxt = v_r;
              seg_cnt_nxt  = CW'(rice_k_r);
              nseg_nxt     = NS_END;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else begin
          pk_req.merge = 1'b1;
          if (pk_rsp.fire) begin
            seg_data_nxt = seg_data_r >> pk_rsp.take;
            seg_cnt_nxt  = seg_cnt_r - CW'(pk_rsp.take);
          end
        end
      end

      // Drop to a byte boundary, then pick the byte-aligned work
      S_ALIGN: begin
        pk_req.align = 1'b1;
        if (pk_rsp.fire) begin
          unique case (op_r)
            FN_RAW_BYTE: begin
              seg_data_nxt = v_r;
              seg_cnt_nxt  = CW'(BYTE_W);
              nseg_nxt     = NS_END;
              state_nxt    = S_PACK;
            end
            FN_VARINT: state_nxt = S_VARINT;
            default:   state_nxt = S_DONE;
          endcase
        end
      end

      // One varint group per cycle while the output stages have room, low group first
      S_VARINT: begin
        if (can_push) begin
          prod_valid = 1'b1;
          if (v_r >= DW'(VARINT_STOP)) begin
            prod_byte = {1'b0, v_r[VARINT_GROUP-1:0]};
            v_nxt     = v_r >> VARINT_GROUP;
          end else begin
            prod_byte = {1'b1, v_r[VARINT_GROUP-1:0]};
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!pend_valid_r || out_free) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (pk_rsp.emit) begin
      prod_valid = 1'b1;
      prod_byte  = pk_rsp.emit_byte;
    end

    // Output register: drop when taken
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    pend_err_nxt   = pend_err_r;

    // Advance the holding stage: a new byte pushes the held one out as not last
    if (prod_valid) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pend_byte_r;
        out_last_nxt  = 1'b0;
        out_err_nxt   = pend_err_r;
      end
      pend_valid_nxt = 1'b1;
      pend_byte_nxt  = prod_byte;
      pend_err_nxt   = prod_err;
    end else if (state_r == S_DONE && pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = pend_byte_r;
      out_last_nxt   = 1'b1;
      out_err_nxt    = pend_err_r;
      pend_valid_nxt = 1'b0;
    end
  end

  // Configuration write and read back
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_AW-1:2] == REG_RICE_K);
  assign rice_k_nxt = cfg_wr ? cfg_pwdata[RICE_K_W-1:0] : rice_k_r;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_RICE_K) ? CFG_DW'(rice_k_r) : '0;

  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.last     = out_last_r;
  assign out_if.error    = out_err_r;

  // Hold state, working registers and output stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rice_k_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rice_k_r     <= rice_k_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    nseg_r      <= nseg_nxt;
    v_r         <= v_nxt;
    x_r         <= x_nxt;
    lx_r        <= lx_nxt;
    len_r       <= len_nxt;
    seg_data_r  <= seg_data_nxt;
    seg_cnt_r   <= seg_cnt_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_err_r  <= pend_err_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !pend_valid_r)
    else $error("holding stage not empty while idle");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    prod_valid |-> can_push)
    else $error("byte produced with both output stages full");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> out_last_r)
    else $error("error result not marked last");

  a_seg_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PACK && pk_req.merge && pk_rsp.fire) |=>
      (seg_cnt_r < $past(seg_cnt_r)))
    else $error("packer merge consumed no bits");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench of the Elias/Rice/varint bit encoder: random and directed requests.
`timescale 1ns / 1ps

module tb;
  import erv_pkg::*;

  // Code outside the operation set; the encoder must ignore it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  // Cycles to let a request with no result finish before touching the register
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_AW-1:0] RICE_K_ADDR = {REG_RICE_K, 2'b00};

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              error;
  } enc_byte_t;

  // Bit stream predictor and queue of bytes still owed by the encoder
  class byte_stream_scoreboard;
    enc_byte_t         expected_bytes[$];
    logic [BYTE_W-1:0] packed_bytes[$];
    logic [BYTE_W-1:0] acc_bits;
    int unsigned       acc_fill;
    logic [RICE_K_W-1:0] rice_k;
    int unsigned       failures;

    function new();
      acc_bits = '0;
      acc_fill = 0;
      rice_k   = '0;
      failures = 0;
    endfunction

    function void set_rice_k(logic [RICE_K_W-1:0] k);
      rice_k = k;
    endfunction

    // Append one finished byte of the current request
    function void append_byte(logic [BYTE_W-1:0] b);
      packed_bytes = {packed_bytes, b};
    endfunction

    // Append n bits of v, LSB first, and pack every full byte
    function void push_bits(logic [63:0] v, int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
        acc_bits[acc_fill] = v[i];
        acc_fill++;
        if (acc_fill == BYTE_W) begin
          append_byte(acc_bits);
          acc_bits = '0;
          acc_fill = 0;
        end
      end
    endfunction

    // Emit a partly filled byte
    function void align_byte();
      if (acc_fill != 0) begin
        append_byte(acc_bits);
        acc_bits = '0;
        acc_fill = 0;
      end
    endfunction

    function int unsigned bit_len(logic [63:0] v);
      for (int i = 63; i >= 0; i--)
        if (v[i]) return i + 1;
      return 0;
    endfunction

    function void push_gamma(logic [63:0] v);
      int unsigned len;
      len = bit_len(v);
      push_bits(64'd0, len - 1);
      push_bits(64'd1, 1);
      push_bits(v, len - 1);
    endfunction

    function void push_delta(logic [63:0] v);
      int unsigned len;
      len = bit_len(v);
      push_gamma(64'(len));
      push_bits(v, len - 1);
    endfunction

    // Predict the bytes that one accepted request produces
    function void encode_request(logic [FUNC_W-1:0] fn, logic [IN_VALUE_W-1:0] value,
                                 logic [WIDTH_W-1:0] width);
      bit                    err;
      int unsigned           w;
      logic [63:0]           quot;
      logic [IN_VALUE_W-1:0] rest;
      enc_byte_t             item;
      err = 1'b0;
      packed_bytes.delete();
      case (fn)
        FN_RAW_WORD: begin
          w = (width > VALUE_BITS_DEF) ? VALUE_BITS_DEF : width;
          push_bits({32'd0, value}, w);
        end
        FN_RAW_BYTE: begin
          align_byte();
          append_byte(value[7:0]);
        end
        FN_GAMMA: begin
          if (value == '0) err = 1'b1;
          else push_gamma({32'd0, value});
        end
        FN_DELTA: begin
          if (value == '0) err = 1'b1;
          else push_delta({32'd0, value});
        end
        FN_RICE: begin
          quot = (({32'd0, value} >> rice_k) + 64'd1) & 64'hFFFF_FFFF;
          if (quot == '0) begin
            err = 1'b1;
          end else begin
            push_delta(quot);
            push_bits({32'd0, value}, rice_k);
          end
        end
        FN_VARINT: begin
          align_byte();
          rest = value;
          while (rest >= VARINT_STOP) begin
            append_byte({1'b0, rest[VARINT_GROUP-1:0]});
            rest = rest >> VARINT_GROUP;
          end
          append_byte({1'b1, rest[VARINT_GROUP-1:0]});
        end
        FN_FLUSH: align_byte();
        default: ;
      endcase
      if (err) begin
        item.data  = '0;
        item.last  = 1'b1;
        item.error = 1'b1;
        expected_bytes = {expected_bytes, item};
      end else begin
        foreach (packed_bytes[i]) begin
          item.data  = packed_bytes[i];
          item.last  = (i == packed_bytes.size() - 1);
          item.error = 1'b0;
          expected_bytes = {expected_bytes, item};
        end
      end
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
    endfunction

    // Compare one result against the oldest expected byte
    function void check_byte(logic [BYTE_W-1:0] data, logic last, logic error);
      enc_byte_t want;
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected result byte %02h last %0b error %0b",
                               data, last, error));
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== data || want.last !== last || want.error !== error)
        note_failure($sformatf({"result differs: expected byte %02h last %0b error %0b, ",
                                "got byte %02h last %0b error %0b"},
                               want.data, want.last, want.error, data, last, error));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  bit idle_on;
  int unsigned rx_hold_req;

  byte_stream_scoreboard sb = new();

  erv_in_if  in_bus();
  erv_out_if out_bus();

  elias_rice_varint_bit_encoder_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_bus),
    .out_if      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sample both channels; check results before noting a new request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_byte(out_bus.out_byte, out_bus.last, out_bus.error);
      if (in_bus.valid && in_bus.ready)
        sb.encode_request(in_bus.func, in_bus.value, in_bus.width);
    end
  end

  // Drive result ready: random stalls, plus a counted hold-off on demand
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= !(idle_on && $urandom_range(99) < 27);
      end
    end
  end

  // Offer one request, idling at random first; return once it is accepted
  task automatic drive_request(logic [FUNC_W-1:0] fn, logic [IN_VALUE_W-1:0] value,
                               logic [WIDTH_W-1:0] width);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 27) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func  <= fn;
    in_bus.value <= value;
    in_bus.width <= width;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
  endtask

  // Hold the request channel low until every expected byte has arrived
  task automatic wait_for_drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Write rice_k while the encoder is idle, then read it back
  task automatic set_rice_k(logic [RICE_K_W-1:0] k);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= RICE_K_ADDR;
    cfg_pwdata  <= CFG_DW'(k);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_rice_k(k);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(k))
      sb.note_failure($sformatf("rice_k read back %0h, expected %0h", cfg_prdata, k));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random requests over all codes; optionally pause halfway until drained
  task automatic run_random(int unsigned count, bit pause_mid);
    logic [FUNC_W-1:0]     fn;
    logic [IN_VALUE_W-1:0] value;
    logic [WIDTH_W-1:0]    width;
    int unsigned           pick;
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) wait_for_drain();
      fn = ($urandom_range(99) < 3) ? FN_UNUSED
                                    : FUNC_W'(FN_RAW_WORD + $urandom_range(6));
      pick = $urandom_range(15);
      if (pick == 0) value = '0;
      else if (pick == 1) value = '1;
      else if (pick < 6) value = $urandom;
      else value = $urandom >> $urandom_range(31);
      width = ($urandom_range(7) == 0) ? WIDTH_W'($urandom_range(63))
                                       : WIDTH_W'($urandom_range(32, 1));
      drive_request(fn, value, width);
    end
  endtask

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    idle_on      = 1'b1;
    rx_hold_req  = 0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_bus.valid = 1'b0;
    in_bus.func  = '0;
    in_bus.value = '0;
    in_bus.width = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty writes, ignored code, field extremes and error cases
    drive_request(FN_RAW_WORD, 32'h0, 6'd0);
    drive_request(FN_FLUSH, 32'h0, 6'd0);
    drive_request(FN_UNUSED, 32'hFFFF_FFFF, 6'd63);
    drive_request(FN_RAW_WORD, 32'hFFFF_FFFF, 6'd32);
    drive_request(FN_RAW_WORD, 32'h0000_0005, 6'd3);
    drive_request(FN_RAW_WORD, 32'hA5A5_5A5A, 6'd63);
    drive_request(FN_GAMMA, 32'h0, 6'd0);
    drive_request(FN_DELTA, 32'h0, 6'd0);
    drive_request(FN_RICE, 32'hFFFF_FFFF, 6'd0);
    drive_request(FN_GAMMA, 32'h1, 6'd0);
    drive_request(FN_GAMMA, 32'hFFFF_FFFF, 6'd0);
    drive_request(FN_DELTA, 32'h1, 6'd0);
    drive_request(FN_DELTA, 32'hFFFF_FFFF, 6'd0);
    drive_request(FN_DELTA, 32'h8000_0000, 6'd0);
    drive_request(FN_RICE, 32'h0, 6'd0);
    drive_request(FN_RICE, 32'hFFFF_FFFE, 6'd0);
    drive_request(FN_RAW_BYTE, 32'hFFFF_FFFF, 6'd0);
    drive_request(FN_VARINT, 32'h0, 6'd0);
    drive_request(FN_VARINT, 32'd127, 6'd0);
    drive_request(FN_VARINT, 32'd128, 6'd0);
    drive_request(FN_VARINT, 32'hFFFF_FFFF, 6'd0);
    drive_request(FN_RAW_WORD, 32'h0000_0015, 6'd5);
    drive_request(FN_FLUSH, 32'hFFFF_FFFF, 6'd63);
    drive_request(FN_RAW_BYTE, 32'h0, 6'd0);

    // Largest remainder width
    set_rice_k(5'd31);
    drive_request(FN_RICE, 32'hFFFF_FFFF, 6'd0);
    drive_request(FN_RICE, 32'h0, 6'd0);
    run_random(20, 1'b0);

    // Stall the receiver long enough to back up the encoder
    set_rice_k(5'd1);
    rx_hold_req = HOLD_OFF_CYCLES;
    run_random(20, 1'b0);

    // Run a stretch with no idling on either side
    set_rice_k(5'($urandom_range(30, 2)));
    idle_on = 1'b0;
    run_random(20, 1'b0);
    idle_on = 1'b1;

    // Pause the sender halfway until all results are back
    set_rice_k(5'd0);
    run_random(20, 1'b1);

    set_rice_k(5'($urandom_range(31)));
    run_random(14, 1'b0);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
